>>> rtl/core/kbir_pkg.sv
package kbir_pkg;

    localparam int TIME_BITS = 48;
    localparam int TS_W      = 48;
    localparam int DELTA_W   = 32;
    localparam int TURN_W    = 16;
    localparam int HELD_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int REQ_W     = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [HELD_W-1:0]    held_t;
    typedef logic [CFG_W-1:0]     cfg_val_t;
    typedef logic [REQ_W-1:0]     req_type_t;

    localparam req_type_t REQ_TURN       = 3'd0;
    localparam req_type_t REQ_BTN_DOWN   = 3'd1;
    localparam req_type_t REQ_BTN_UP     = 3'd2;
    localparam req_type_t REQ_ADVANCE    = 3'd3;
    localparam req_type_t REQ_TAKE_FRAME = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam cfg_val_t DEBOUNCE_RST   = 16'd30;
    localparam cfg_val_t LONG_PRESS_RST = 16'd800;

    localparam held_t HELD_MAX = '1;

    // span from -> to in ms, zero if not forward, saturated to the held width
    function automatic held_t sat_span(time_t from_t, time_t to_t);
        logic [TIME_BITS:0] d;
        d = {1'b0, to_t} - {1'b0, from_t};
        if (d[TIME_BITS] || d[TIME_BITS-1:0] == '0)
            return '0;
        if (d[TIME_BITS-1:0] > time_t'(HELD_MAX))
            return HELD_MAX;
        return d[HELD_W-1:0];
    endfunction

endpackage

>>> rtl/core/kbir_req_if.sv
interface kbir_req_if;
    import kbir_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [TS_W-1:0]           timestamp_ms;
    logic signed [DELTA_W-1:0] turn_delta;

    modport source (output valid, output req_type, output timestamp_ms, output turn_delta,
                    input ready);
    modport sink   (input valid, input req_type, input timestamp_ms, input turn_delta,
                    output ready);
endinterface

>>> rtl/core/kbir_frame_if.sv
interface kbir_frame_if;
    import kbir_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TURN_W-1:0] turn_count;
    logic                     was_pressed;
    logic                     was_released;
    logic                     was_clicked;
    logic                     was_long_pressed;
    logic [HELD_W-1:0]        held_time_ms;

    modport source (output valid, output turn_count, output was_pressed, output was_released,
                    output was_clicked, output was_long_pressed, output held_time_ms,
                    input ready);
    modport sink   (input valid, input turn_count, input was_pressed, input was_released,
                    input was_clicked, input was_long_pressed, input held_time_ms,
                    output ready);
endinterface

>>> rtl/core/kbir_cfg_if.sv
interface kbir_cfg_if;
    import kbir_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> rtl/core/knob_button_input_reducer.sv
// Order: a request word is registered on acceptance and processed in the next cycle unless stalled;
// a take-frame result is loaded into the output register as the word is processed.
// Throughput: one request word per cycle; a take-frame stalls only while the
// previous frame word is still waiting on the output.
// Reset: all event state and pending frame contents clear, debounce_ms = 30,
// long_press_ms = 800. The configuration port is always ready.
module knob_button_input_reducer (
    input  logic         clk,
    input  logic         rst_n,
    kbir_cfg_if.sink     cfg,
    kbir_req_if.sink     req,
    kbir_frame_if.source frame
);
    import kbir_pkg::*;

    // configuration
    cfg_val_t debounce_reg;
    cfg_val_t long_press_reg;

    // input register
    logic                      inq_valid_reg;
    req_type_t                 inq_type_reg;
    time_t                     inq_ts_reg;
    logic signed [DELTA_W-1:0] inq_delta_reg;

    // block state
    time_t                    cur_time_reg,    cur_time_next;
    logic                     raw_down_reg,    raw_down_next;
    time_t                    raw_change_reg,  raw_change_next;
    logic                     stable_down_reg, stable_down_next;
    time_t                    press_start_reg, press_start_next;
    logic                     long_rep_reg,    long_rep_next;
    logic signed [TURN_W-1:0] turn_reg,        turn_next;
    logic                     f_pressed_reg,   f_pressed_next;
    logic                     f_released_reg,  f_released_next;
    logic                     f_clicked_reg,   f_clicked_next;
    logic                     f_long_reg,      f_long_next;
    held_t                    held_reg,        held_next;

    // output register
    logic                     out_valid_reg;
    logic signed [TURN_W-1:0] out_turn_reg;
    logic                     out_pressed_reg;
    logic                     out_released_reg;
    logic                     out_clicked_reg;
    logic                     out_long_reg;
    held_t                    out_held_reg;

    logic is_frame;
    logic fire;
    logic load_out;

    assign is_frame = (inq_type_reg == REQ_TAKE_FRAME);
    assign fire     = inq_valid_reg && (!is_frame || !out_valid_reg || frame.ready);
    assign load_out = fire && is_frame;

    assign req.ready = !inq_valid_reg || fire;
    assign cfg.ready = 1'b1;

    assign frame.valid            = out_valid_reg;
    assign frame.turn_count       = out_turn_reg;
    assign frame.was_pressed      = out_pressed_reg;
    assign frame.was_released     = out_released_reg;
    assign frame.was_clicked      = out_clicked_reg;
    assign frame.was_long_pressed = out_long_reg;
    assign frame.held_time_ms     = out_held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_DEBOUNCE:   debounce_reg   <= cfg.data;
                CFG_LONG_PRESS: long_press_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        logic [TIME_BITS:0]   age;
        logic                 sw;
        time_t                at;
        held_t                h_at;
        held_t                h_now;
        logic                 lpr;
        logic signed [TURN_W+DELTA_W-16:0] sum;
        logic                 live;

        cur_time_next    = cur_time_reg;
        raw_down_next    = raw_down_reg;
        raw_change_next  = raw_change_reg;
        stable_down_next = stable_down_reg;
        press_start_next = press_start_reg;
        long_rep_next    = long_rep_reg;
        turn_next        = turn_reg;
        f_pressed_next   = f_pressed_reg;
        f_released_next  = f_released_reg;
        f_clicked_next   = f_clicked_reg;
        f_long_next      = f_long_reg;
        held_next        = held_reg;
        h_now            = '0;
        lpr              = long_rep_reg;

        // debounce: raw level has persisted long enough to become stable
        age = {1'b0, inq_ts_reg} - {1'b0, raw_change_reg};
        sw  = (raw_down_reg != stable_down_reg) && !age[TIME_BITS]
              && (age[TIME_BITS-1:0] >= time_t'(debounce_reg));
        at  = raw_change_reg + time_t'(debounce_reg);
        h_at = sat_span(press_start_reg, at);

        sum = $signed({{(DELTA_W+1-TURN_W){turn_reg[TURN_W-1]}}, turn_reg})
              + $signed({inq_delta_reg[DELTA_W-1], inq_delta_reg});

        live = fire && (inq_type_reg == REQ_TURN || inq_type_reg == REQ_BTN_DOWN
                        || inq_type_reg == REQ_BTN_UP || inq_type_reg == REQ_ADVANCE)
               && (inq_ts_reg >= cur_time_reg);

        if (fire && is_frame)
        begin
            turn_next       = '0;
            f_pressed_next  = 1'b0;
            f_released_next = 1'b0;
            f_clicked_next  = 1'b0;
            f_long_next     = 1'b0;
            if (!stable_down_reg)
                held_next = '0;
        end
        else if (live)
        begin
            lpr = long_rep_reg;
            if (sw)
            begin
                // close out the old stable level at the switch instant
                if (stable_down_reg && !lpr && (h_at >= held_t'(long_press_reg)))
                begin
                    lpr         = 1'b1;
                    f_long_next = 1'b1;
                end
                stable_down_next = raw_down_reg;
                if (raw_down_reg)
                begin
                    press_start_next = at;
                    lpr              = 1'b0;
                    f_pressed_next   = 1'b1;
                end
                else
                begin
                    f_released_next = 1'b1;
                    f_clicked_next  = !lpr;
                end
                held_next = '0;
            end

            h_now = sat_span(press_start_next, inq_ts_reg);
            if (stable_down_next)
            begin
                held_next = h_now;
                if (!lpr && (h_now >= held_t'(long_press_reg)))
                begin
                    lpr         = 1'b1;
                    f_long_next = 1'b1;
                end
            end
            long_rep_next = lpr;
            cur_time_next = inq_ts_reg;

            if (inq_type_reg == REQ_TURN)
            begin
                if (sum > $signed((TURN_W+DELTA_W-15)'(32767)))
                    turn_next = 16'sh7FFF;
                else if (sum < $signed(-(TURN_W+DELTA_W-15)'(32768)))
                    turn_next = 16'sh8000;
                else
                    turn_next = sum[TURN_W-1:0];
            end
            else if (inq_type_reg == REQ_BTN_DOWN || inq_type_reg == REQ_BTN_UP)
            begin
                if ((inq_type_reg == REQ_BTN_DOWN) != raw_down_reg)
                begin
                    raw_down_next   = (inq_type_reg == REQ_BTN_DOWN);
                    raw_change_next = inq_ts_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            cur_time_reg    <= '0;
            raw_down_reg    <= 1'b0;
            raw_change_reg  <= '0;
            stable_down_reg <= 1'b0;
            press_start_reg <= '0;
            long_rep_reg    <= 1'b0;
            turn_reg        <= '0;
            f_pressed_reg   <= 1'b0;
            f_released_reg  <= 1'b0;
            f_clicked_reg   <= 1'b0;
            f_long_reg      <= 1'b0;
            held_reg        <= '0;
        end
        else
        begin
            if (req.ready)
                inq_valid_reg <= req.valid;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (frame.ready)
                out_valid_reg <= 1'b0;
            cur_time_reg    <= cur_time_next;
            raw_down_reg    <= raw_down_next;
            raw_change_reg  <= raw_change_next;
            stable_down_reg <= stable_down_next;
            press_start_reg <= press_start_next;
            long_rep_reg    <= long_rep_next;
            turn_reg        <= turn_next;
            f_pressed_reg   <= f_pressed_next;
            f_released_reg  <= f_released_next;
            f_clicked_reg   <= f_clicked_next;
            f_long_reg      <= f_long_next;
            held_reg        <= held_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            inq_type_reg  <= req.req_type;
            inq_ts_reg    <= time_t'(req.timestamp_ms);
            inq_delta_reg <= req.turn_delta;
        end
        if (load_out)
        begin
            out_turn_reg     <= turn_reg;
            out_pressed_reg  <= f_pressed_reg;
            out_released_reg <= f_released_reg;
            out_clicked_reg  <= f_clicked_reg;
            out_long_reg     <= f_long_reg;
            out_held_reg     <= held_reg;
        end
    end

endmodule

>>> verif/tb_knob_button_input_reducer.sv
`timescale 1ns / 100ps

module tb_knob_button_input_reducer;
    import kbir_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 90;

    // request codes the block must ignore
    localparam req_type_t REQ_BAD_LO = 3'd5;
    localparam req_type_t REQ_BAD_HI = 3'd7;
    // no register behind this index; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic signed [TURN_W-1:0] turn;
        logic                     pressed;
        logic                     released;
        logic                     clicked;
        logic                     long_hit;
        held_t                    held;
    } frame_t;

    typedef struct {
        bit     typed;
        frame_t fr;
    } req_note_t;

    typedef struct {
        req_type_t                 k;
        time_t                     ts;
        logic signed [DELTA_W-1:0] dl;
        bit                        typed;
        frame_t                    fr;
    } dir_row_t;

    logic clk;
    logic rst_n;

    kbir_req_if   req_bus();
    kbir_frame_if frame_bus();
    kbir_cfg_if   cfg_bus();

    knob_button_input_reducer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .frame (frame_bus)
    );

    // reducer state as the testbench sees it
    time_t                    cur_t;
    time_t                    raw_t;
    time_t                    press_t;
    bit                       raw_dn;
    bit                       stab_dn;
    bit                       lp_done;
    logic signed [TURN_W-1:0] acc_turn;
    bit                       f_press;
    bit                       f_rel;
    bit                       f_click;
    bit                       f_long;
    held_t                    acc_held;
    cfg_val_t                 deb_ms;
    cfg_val_t                 lp_ms;

    frame_t    frames_due[$];
    req_note_t req_notes[$];
    dir_row_t  dir_rows[$];

    int unsigned err_cnt   = 0;
    int unsigned n_sent    = 0;
    int unsigned n_cycles  = 0;
    bit          gaps_on   = 1'b1;
    bit          hold_req  = 1'b0;
    bit          near_top  = 1'b0;
    time_t       t_now     = '0;
    int unsigned deb_now   = 30;
    int unsigned lp_now    = 800;
    int unsigned step_hi   = 204;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (n_cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n_cycles++;
        end
        $display("knob_button_input_reducer regression: fail");
        $finish;
    end

    task automatic log_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic clear_model();
        cur_t    = '0;
        raw_t    = '0;
        press_t  = '0;
        raw_dn   = 1'b0;
        stab_dn  = 1'b0;
        lp_done  = 1'b0;
        acc_turn = '0;
        f_press  = 1'b0;
        f_rel    = 1'b0;
        f_click  = 1'b0;
        f_long   = 1'b0;
        acc_held = '0;
        deb_ms   = DEBOUNCE_RST;
        lp_ms    = LONG_PRESS_RST;
    endtask

    function automatic held_t span_ms(time_t from_t, time_t to_t);
        logic [63:0] d;
        if (to_t <= from_t)
            return '0;
        d = 64'(to_t) - 64'(from_t);
        return (d > 64'hFFFF_FFFF) ? '1 : d[HELD_W-1:0];
    endfunction

    task automatic update_held(time_t at);
        if (stab_dn)
        begin
            acc_held = span_ms(press_t, at);
            if (!lp_done && acc_held >= held_t'(lp_ms))
            begin
                lp_done = 1'b1;
                f_long  = 1'b1;
            end
        end
    endtask

    task automatic advance_to(time_t now);
        time_t at;
        if (raw_dn != stab_dn && now >= raw_t && (now - raw_t) >= time_t'(deb_ms))
        begin
            // the switch counts as happening when the debounce window closed
            at = raw_t + time_t'(deb_ms);
            update_held(at);
            stab_dn = raw_dn;
            if (stab_dn)
            begin
                press_t = at;
                lp_done = 1'b0;
                f_press = 1'b1;
            end
            else
            begin
                f_rel   = 1'b1;
                f_click = !lp_done;
            end
            acc_held = '0;
        end
        update_held(now);
        cur_t = now;
    endtask

    task automatic reduce_req(input req_type_t k, input time_t ts,
                              input logic signed [DELTA_W-1:0] dl,
                              output bit got, output frame_t fr);
        longint s;
        got = 1'b0;
        fr  = '0;
        if (k == REQ_TAKE_FRAME)
        begin
            got         = 1'b1;
            fr.turn     = acc_turn;
            fr.pressed  = f_press;
            fr.released = f_rel;
            fr.clicked  = f_click;
            fr.long_hit = f_long;
            fr.held     = acc_held;
            acc_turn = '0;
            f_press  = 1'b0;
            f_rel    = 1'b0;
            f_click  = 1'b0;
            f_long   = 1'b0;
            if (!stab_dn)
                acc_held = '0;
        end
        else if (k < REQ_TAKE_FRAME && ts >= cur_t)
        begin
            advance_to(ts);
            if (k == REQ_TURN)
            begin
                s = longint'(acc_turn) + longint'(dl);
                if (s > 32767)
                    acc_turn = 16'sh7FFF;
                else if (s < -32768)
                    acc_turn = 16'sh8000;
                else
                    acc_turn = TURN_W'(s);
            end
            else if (k == REQ_BTN_DOWN || k == REQ_BTN_UP)
            begin
                if ((k == REQ_BTN_DOWN) != raw_dn)
                begin
                    raw_dn = (k == REQ_BTN_DOWN);
                    raw_t  = ts;
                end
            end
        end
    endtask

    task automatic take_req();
        req_note_t note;
        bit        got;
        frame_t    fr;
        note = req_notes.pop_front();
        reduce_req(req_bus.req_type, req_bus.timestamp_ms, req_bus.turn_delta, got, fr);
        if (got)
            frames_due.push_back(note.typed ? note.fr : fr);
    endtask

    task automatic take_cfg();
        case (cfg_bus.addr)
            CFG_DEBOUNCE:   deb_ms = cfg_bus.data;
            CFG_LONG_PRESS: lp_ms  = cfg_bus.data;
            default: ;
        endcase
    endtask

    task automatic check_frame();
        frame_t want;
        if (frames_due.size() == 0)
            log_mismatch("frame word with no frame expected");
        else
        begin
            want = frames_due.pop_front();
            if (frame_bus.turn_count !== want.turn)
                log_mismatch($sformatf("turn_count got %0d want %0d",
                                       frame_bus.turn_count, want.turn));
            if (frame_bus.was_pressed !== want.pressed)
                log_mismatch($sformatf("was_pressed got %b want %b",
                                       frame_bus.was_pressed, want.pressed));
            if (frame_bus.was_released !== want.released)
                log_mismatch($sformatf("was_released got %b want %b",
                                       frame_bus.was_released, want.released));
            if (frame_bus.was_clicked !== want.clicked)
                log_mismatch($sformatf("was_clicked got %b want %b",
                                       frame_bus.was_clicked, want.clicked));
            if (frame_bus.was_long_pressed !== want.long_hit)
                log_mismatch($sformatf("was_long_pressed got %b want %b",
                                       frame_bus.was_long_pressed, want.long_hit));
            if (frame_bus.held_time_ms !== want.held)
                log_mismatch($sformatf("held_time_ms got %0d want %0d",
                                       frame_bus.held_time_ms, want.held));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (req_bus.valid && req_bus.ready)
                take_req();
            if (cfg_bus.valid && cfg_bus.ready)
                take_cfg();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && frame_bus.valid && frame_bus.ready)
            check_frame();
    end

    // frame sink: random stalls, plus one long hold-off on request
    initial
    begin
        frame_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                frame_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            frame_bus.ready <= !gaps_on || ($urandom_range(99) >= 26);
        end
    end

    function automatic time_t rand_ts();
        return time_t'({$urandom, $urandom});
    endfunction

    function automatic logic signed [DELTA_W-1:0] rand_delta();
        int unsigned               r;
        logic signed [DELTA_W-1:0] d;
        r = $urandom_range(99);
        if (r < 60)
            return $signed(DELTA_W'($urandom_range(0, 10))) - 5;
        if (r < 75)
        begin
            d = DELTA_W'($urandom_range(30000, 40000));
            return $urandom_range(1) ? d : -d;
        end
        if (r < 85)
            return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        return $urandom;
    endfunction

    function automatic frame_t mk_frame(logic signed [TURN_W-1:0] turn, logic p, logic r,
                                        logic c, logic l, held_t held);
        frame_t f;
        f.turn     = turn;
        f.pressed  = p;
        f.released = r;
        f.clicked  = c;
        f.long_hit = l;
        f.held     = held;
        return f;
    endfunction

    task automatic add_row(req_type_t k, time_t ts, logic signed [DELTA_W-1:0] dl);
        dir_row_t row;
        row.k     = k;
        row.ts    = ts;
        row.dl    = dl;
        row.typed = 1'b0;
        row.fr    = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_typed(frame_t fr);
        dir_row_t row;
        row.k     = REQ_TAKE_FRAME;
        row.ts    = '0;
        row.dl    = '0;
        row.typed = 1'b1;
        row.fr    = fr;
        dir_rows.push_back(row);
    endtask

    task automatic put_req(req_type_t k, time_t ts, logic signed [DELTA_W-1:0] dl,
                           bit typed, frame_t fr);
        req_note_t note;
        if (gaps_on)
            while ($urandom_range(99) < 26)
            begin
                req_bus.valid <= 1'b0;
                @(posedge clk);
            end
        note.typed = typed;
        note.fr    = fr;
        req_notes.push_back(note);
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= k;
        req_bus.timestamp_ms <= ts;
        req_bus.turn_delta   <= dl;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send(req_type_t k, time_t ts, logic signed [DELTA_W-1:0] dl);
        put_req(k, ts, dl, 1'b0, '0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_val_t val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.addr  <= idx;
        cfg_bus.data  <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
    endtask

    // drop valid, wait out every frame and the pipeline behind the last word
    task automatic settle();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic noise_item();
        int unsigned r;
        time_t       ts;
        r = $urandom_range(99);
        if (r < 12)
            send(REQ_TAKE_FRAME, rand_ts(), rand_delta());
        else if (r < 15)
            send(req_type_t'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), rand_ts(), rand_delta());
        else if (r < 21 && t_now != '0)
        begin
            // stale event, behind the current time
            ts = rand_ts() % t_now;
            send(req_type_t'($urandom_range(REQ_TURN, REQ_ADVANCE)), ts, rand_delta());
        end
        else
        begin
            if (r < 24 && !near_top)
                t_now += time_t'(64'h1_0000_0000) + time_t'($urandom_range(0, 1 << 20));
            else
                t_now += time_t'($urandom_range(0, step_hi));
            send(req_type_t'($urandom_range(REQ_TURN, REQ_ADVANCE)), t_now, rand_delta());
        end
    endtask

    // press, hold for a while with turns and frames, release
    task automatic press_gesture();
        int unsigned r;
        int unsigned parts;
        time_t       hold;
        req_type_t   k;
        t_now += time_t'($urandom_range(0, step_hi));
        send(REQ_BTN_DOWN, t_now, rand_delta());
        if ($urandom_range(3) == 0)
        begin
            // contact bounce inside the debounce window
            t_now += time_t'($urandom_range(0, deb_now / 2));
            send(REQ_BTN_UP, t_now, rand_delta());
            t_now += time_t'($urandom_range(0, deb_now / 2));
            send(REQ_BTN_DOWN, t_now, rand_delta());
        end
        t_now += time_t'(deb_now) + time_t'($urandom_range(0, 2));
        send(REQ_ADVANCE, t_now, rand_delta());
        r = $urandom_range(9);
        if (r == 0 && !near_top)
            hold = time_t'(64'h1_0000_0000) + time_t'($urandom_range(0, 1000));
        else if (r < 5)
            hold = time_t'($urandom_range(0, lp_now));
        else
            hold = time_t'(lp_now) + time_t'($urandom_range(0, lp_now + 10));
        parts = $urandom_range(1, 3);
        repeat (parts)
        begin
            t_now += hold / parts;
            case ($urandom_range(2))
                0:       k = REQ_TURN;
                1:       k = REQ_ADVANCE;
                default: k = REQ_TAKE_FRAME;
            endcase
            send(k, t_now, rand_delta());
        end
        send(REQ_BTN_UP, t_now, rand_delta());
        t_now += time_t'(deb_now) + time_t'($urandom_range(0, 2));
        send(REQ_ADVANCE, t_now, rand_delta());
        if ($urandom_range(1))
            send(REQ_TAKE_FRAME, rand_ts(), rand_delta());
    endtask

    initial
    begin
        cfg_val_t    d;
        cfg_val_t    l;
        int unsigned goal;

        rst_n                <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.req_type     <= REQ_TURN;
        req_bus.timestamp_ms <= '0;
        req_bus.turn_delta   <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.addr         <= CFG_DEBOUNCE;
        cfg_bus.data         <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset config: debounce 30, long press 800
        add_typed(mk_frame(16'sh0000, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        add_row(REQ_TURN, 0, 32'sh7FFF_FFFF);
        add_typed(mk_frame(16'sh7FFF, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        add_row(REQ_TURN, 0, 32'sh8000_0000);
        add_typed(mk_frame(16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0, '0));
        add_row(REQ_TURN, 5, -32'sd1);
        add_row(REQ_BTN_DOWN, 10, 0);
        add_row(REQ_ADVANCE, 39, 0);        // one short of the window
        add_row(REQ_ADVANCE, 40, 0);        // stable press
        add_row(REQ_TAKE_FRAME, 0, 0);
        add_row(REQ_BTN_UP, 50, 0);
        add_row(REQ_BTN_DOWN, 60, 0);       // bounce back before the window
        add_row(REQ_ADVANCE, 100, 0);
        add_row(REQ_TURN, 20, 5);           // stale
        add_row(REQ_BTN_UP, 0, 0);          // stale
        add_row(REQ_ADVANCE, 840, 0);       // held reaches the long-press threshold
        add_row(REQ_TAKE_FRAME, 0, 0);
        add_row(REQ_BTN_UP, 900, 0);
        add_row(REQ_ADVANCE, 930, 0);       // release after long press: no click
        add_row(REQ_TAKE_FRAME, 0, 0);
        add_row(REQ_BAD_LO, '1, -32'sd1);
        add_row(REQ_BAD_HI, '1, 32'sh7FFF_FFFF);
        add_row(REQ_BTN_DOWN, 1000, 0);
        add_row(REQ_ADVANCE, 1030, 0);
        add_row(REQ_BTN_UP, 1100, 0);
        add_row(REQ_ADVANCE, 1130, 0);      // short press: click
        add_row(REQ_TAKE_FRAME, '1, 32'sh8000_0000);
        foreach (dir_rows[i])
            put_req(dir_rows[i].k, dir_rows[i].ts, dir_rows[i].dl,
                    dir_rows[i].typed, dir_rows[i].fr);
        t_now = 1130;
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin d = DEBOUNCE_RST; l = LONG_PRESS_RST; end
                1:       begin d = 16'd0;     l = 16'd0;     end
                2:       begin d = 16'hFFFF;  l = 16'hFFFF;  end
                3:       begin d = 16'd5;     l = 16'd40;    end
                4:       begin d = cfg_val_t'($urandom); l = cfg_val_t'($urandom); end
                5:       begin d = 16'd1;     l = 16'hFFFF;  end
                6:       begin d = 16'hFFFF;  l = 16'd0;     end
                default: begin d = 16'd10;    l = 16'd100;   end
            endcase
            write_reg(CFG_DEBOUNCE, d);
            write_reg(CFG_LONG_PRESS, l);
            write_reg(CFG_SPARE, cfg_val_t'($urandom));
            cfg_bus.valid <= 1'b0;
            deb_now = 32'(d);
            lp_now  = 32'(l);
            step_hi = 32'((d > l) ? d : l) / 4 + 4;
            gaps_on = (p != 3);
            if (p == 3)
                hold_req = 1'b1;
            if (p == PHASES - 1)
            begin
                // last phase runs close to the top of the time range
                near_top = 1'b1;
                t_now    = '1;
                t_now   -= 48'hFF_FFFF;
            end
            goal = n_sent + PHASE_WORDS;
            while (n_sent < goal)
            begin
                if ($urandom_range(99) < 35)
                    press_gesture();
                else
                    noise_item();
            end
            if (p == PHASES - 1)
            begin
                send(REQ_BTN_DOWN, '1, rand_delta());
                send(REQ_ADVANCE, '1, rand_delta());
                send(REQ_TAKE_FRAME, '1, rand_delta());
            end
            settle();
        end

        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("knob_button_input_reducer regression: pass");
        else
            $display("knob_button_input_reducer regression: fail");
        $finish;
    end

endmodule
